// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sorted priority queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/spq_pkg.sv -----
package spq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PRIO_WIDTH = 16;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QFILL_W    = $clog2(QDEPTH + 1);

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_INSERT  = 2'd0;
	localparam cmd_t CMD_DELETE  = 2'd1;
	localparam cmd_t CMD_DISPLAY = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t STAT_OK    = 2'd0;
	localparam status_t STAT_EMPTY = 2'd1;
	localparam status_t STAT_FULL  = 2'd2;

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [PRIO_WIDTH-1:0] prio_t;

	typedef struct packed {
		cmd_t  cmd;
		data_t data;
		prio_t prio;
	} spq_op_t;

endpackage

// ----- sv/spq_if.sv -----
interface spq_req_if import spq_pkg::*; ();
	logic  valid;
	logic  ready;
	cmd_t  cmd;
	data_t item_data;
	prio_t item_priority;

	modport source (output valid, output cmd, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input cmd, input item_data, input item_priority,
		output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
	logic    valid;
	logic    ready;
	data_t   out_data;
	prio_t   out_priority;
	status_t status;
	logic    last;

	modport source (output valid, output out_data, output out_priority, output status,
		output last, input ready);
	modport sink (input valid, input out_data, input out_priority, input status,
		input last, output ready);
endinterface

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue of up to DEPTH entries held in a shift-register store, lowest
// priority value at the front and equal priorities in arrival order. Commands enter a
// two-entry queue and are executed one at a time behind it; each result sits in a single
// output register. Insert and delete run at one per cycle while results are taken, each
// passing through the queue and then the output register. Display enters a show state
// and loads the entries in order as the output register frees; an empty store gives a
// single empty result. Unused command codes are accepted and produce no result.
module sorted_priority_queue import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	logic    op_valid;
	logic    op_ready;
	spq_op_t op;

	spq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready)
	);

	spq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.op_ready (op_ready),
		.rsp      (rsp)
	);

endmodule

// ----- sv/spq_front.sv -----
`include "assert_macros.svh"

module spq_front import spq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	spq_req_if.sink       req,
	output logic          op_valid,
	output spq_op_t       op,
	input  logic          op_ready
);

	spq_op_t            buf_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;
	logic               push;
	logic               pop;

	// Unused command codes are accepted and dropped here.
	assign req.ready = (fill_q != QFILL_W'(QDEPTH));
	assign push      = req.valid && req.ready &&
		(req.cmd inside {CMD_INSERT, CMD_DELETE, CMD_DISPLAY});
	assign op_valid  = (fill_q != '0);
	assign op        = buf_q[rd_ptr_q];
	assign pop       = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= '{cmd: req.cmd, data: req.item_data, prio: req.item_priority};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_W'(1);
			end
		end
	end

	`SPQ_ASSERT(a_fill_bound, fill_q <= QFILL_W'(QDEPTH), "queue fill exceeds its depth")
	`SPQ_ASSERT_NEXT(a_fill_grow, push && !pop, fill_q == $past(fill_q) + QFILL_W'(1), "queue fill did not grow on push")

endmodule

// ----- sv/spq_back.sv -----
`include "assert_macros.svh"

module spq_back import spq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  spq_op_t       op,
	output logic          op_ready,
	spq_rsp_if.source     rsp
);

	typedef enum logic {S_IDLE, S_SHOW} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	data_t             data_q [DEPTH];
	prio_t             prio_q [DEPTH];
	logic              res_valid_q;
	data_t             res_data_q;
	prio_t             res_prio_q;
	status_t           res_status_q;
	logic              res_last_q;

	logic              load_ok;
	logic              take;
	logic              full;
	logic              empty;
	logic              show_last;
	logic [DEPTH-1:0]  place;

	assign load_ok   = !res_valid_q || rsp.ready;
	assign op_ready  = (state_q == S_IDLE) && load_ok;
	assign take      = op_valid && op_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign show_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// A slot takes part in the shift when it is empty or holds a strictly larger priority.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			place[i] = (CNT_W'(i) >= count_q) || (prio_q[i] > op.prio);
		end
	end

	always_ff @(posedge clk) begin
		if (take && op.cmd == CMD_INSERT && !full) begin
			if (place[0]) begin
				data_q[0] <= op.data;
				prio_q[0] <= op.prio;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (place[i]) begin
					data_q[i] <= place[i-1] ? data_q[i-1] : op.data;
					prio_q[i] <= place[i-1] ? prio_q[i-1] : op.prio;
				end
			end
		end else if (take && op.cmd == CMD_DELETE && !empty) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				data_q[i] <= data_q[i+1];
				prio_q[i] <= prio_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			idx_q        <= '0;
			res_valid_q  <= 1'b0;
			res_data_q   <= '0;
			res_prio_q   <= '0;
			res_status_q <= STAT_OK;
			res_last_q   <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						case (op.cmd)
							CMD_INSERT: begin
								res_valid_q  <= 1'b1;
								res_data_q   <= '0;
								res_prio_q   <= '0;
								res_status_q <= full ? STAT_FULL : STAT_OK;
								res_last_q   <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_DELETE: begin
								res_valid_q  <= 1'b1;
								res_data_q   <= empty ? '0 : data_q[0];
								res_prio_q   <= empty ? '0 : prio_q[0];
								res_status_q <= empty ? STAT_EMPTY : STAT_OK;
								res_last_q   <= 1'b1;
								if (!empty) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							CMD_DISPLAY: begin
								if (empty) begin
									res_valid_q  <= 1'b1;
									res_data_q   <= '0;
									res_prio_q   <= '0;
									res_status_q <= STAT_EMPTY;
									res_last_q   <= 1'b1;
								end else begin
									state_q <= S_SHOW;
									idx_q   <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHOW: begin
					if (load_ok) begin
						res_valid_q  <= 1'b1;
						res_data_q   <= data_q[idx_q];
						res_prio_q   <= prio_q[idx_q];
						res_status_q <= STAT_OK;
						res_last_q   <= show_last;
						idx_q        <= idx_q + IDX_W'(1);
						if (show_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = res_valid_q;
	assign rsp.out_data     = res_data_q;
	assign rsp.out_priority = res_prio_q;
	assign rsp.status       = res_status_q;
	assign rsp.last         = res_last_q;

	`SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count exceeds the store depth")
	`SPQ_ASSERT(a_show_range, state_q != S_SHOW || CNT_W'(idx_q) < count_q, "display index past the last entry")

endmodule

// ----- tb/sorted_priority_queue_test.sv -----
module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam cmd_t CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 300000;
	localparam int ITEMS_PER_PHASE = 32;
	localparam int PRINT_CAP = 100;

	typedef struct {
		data_t   data;
		prio_t   prio;
		status_t status;
		logic    last;
	} queue_result_t;

	class queue_mirror;
		data_t         slot_data[DEPTH];
		prio_t         slot_prio[DEPTH];
		int            fill;
		queue_result_t pending[$];
		int            mismatches;
		int            checked;
		int            n_insert;
		int            n_delete;
		int            n_display;
		int            n_full;
		int            n_empty;

		function new();
			fill = 0;
			mismatches = 0;
			checked = 0;
			n_insert = 0;
			n_delete = 0;
			n_display = 0;
			n_full = 0;
			n_empty = 0;
		endfunction

		function void expect_result(data_t d, prio_t p, status_t s, logic l);
			queue_result_t r;
			r.data = d;
			r.prio = p;
			r.status = s;
			r.last = l;
			pending.push_back(r);
			if (s == STAT_FULL)
				n_full++;
			if (s == STAT_EMPTY)
				n_empty++;
		endfunction

		// Mirrors the store for one accepted request transaction.
		function void note_command(cmd_t c, data_t d, prio_t p);
			int pos;
			int i;
			case (c)
				CMD_INSERT: begin
					n_insert++;
					if (fill >= DEPTH) begin
						expect_result('0, '0, STAT_FULL, 1'b1);
					end else begin
						pos = fill;
						for (i = 0; i < fill; i++) begin
							if (slot_prio[i] > p) begin
								pos = i;
								break;
							end
						end
						for (i = fill; i > pos; i--) begin
							slot_data[i] = slot_data[i-1];
							slot_prio[i] = slot_prio[i-1];
						end
						slot_data[pos] = d;
						slot_prio[pos] = p;
						fill++;
						expect_result('0, '0, STAT_OK, 1'b1);
					end
				end
				CMD_DELETE: begin
					n_delete++;
					if (fill == 0) begin
						expect_result('0, '0, STAT_EMPTY, 1'b1);
					end else begin
						expect_result(slot_data[0], slot_prio[0], STAT_OK, 1'b1);
						for (i = 1; i < fill; i++) begin
							slot_data[i-1] = slot_data[i];
							slot_prio[i-1] = slot_prio[i];
						end
						fill--;
					end
				end
				CMD_DISPLAY: begin
					n_display++;
					if (fill == 0) begin
						expect_result('0, '0, STAT_EMPTY, 1'b1);
					end else begin
						for (i = 0; i < fill; i++)
							expect_result(slot_data[i], slot_prio[i], STAT_OK, i == fill - 1);
					end
				end
				default: begin
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(data_t d, prio_t p, status_t s, logic l);
			queue_result_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result data %0d prio %0d status %0d with none pending",
					d, p, s));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (d !== want.data)
				report_mismatch($sformatf("out_data %0d, wanted %0d", d, want.data));
			if (p !== want.prio)
				report_mismatch($sformatf("out_priority %0d, wanted %0d", p, want.prio));
			if (s !== want.status)
				report_mismatch($sformatf("status %0d, wanted %0d", s, want.status));
			if (l !== want.last)
				report_mismatch($sformatf("last %0b, wanted %0b", l, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   cycle_count;

	spq_req_if req_ch();
	spq_rsp_if rsp_ch();

	queue_mirror mirror = new();

	sorted_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_INSERT;
		req_ch.item_data = '0;
		req_ch.item_priority = '0;
		rsp_ch.ready = 1'b0;
		tx_idle_pct = 9;
		rx_idle_pct = 80;
		cycle_count = 0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				mirror.check_result(rsp_ch.out_data, rsp_ch.out_priority, rsp_ch.status,
					rsp_ch.last);
			if (req_ch.valid && req_ch.ready)
				mirror.note_command(req_ch.cmd, req_ch.item_data, req_ch.item_priority);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				mirror.pending.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic prio_t pick_priority();
		if ($urandom_range(1))
			return prio_t'($urandom);
		return prio_t'($signed($urandom_range(6)) - 3);
	endfunction

	task automatic send_item(cmd_t c, data_t d, prio_t p);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.item_data <= d;
		req_ch.item_priority <= p;
		do
			@(posedge clk);
		while (!req_ch.ready);
		if ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Holds the request side idle until every pending result has been taken.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (mirror.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(int tx_pct, int rx_pct);
		int   sent;
		int   insert_weight;
		int   roll;
		cmd_t c;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		insert_weight = 50;
		while (sent < ITEMS_PER_PHASE) begin
			if (sent % 12 == 0)
				insert_weight = $urandom_range(1) ? 75 : 30;
			if (sent == ITEMS_PER_PHASE / 2 && tx_pct == 0)
				drain();
			roll = $urandom_range(99);
			if (roll < 3)
				c = CMD_SPARE;
			else if (roll < 13)
				c = CMD_DISPLAY;
			else if (roll < 13 + (87 * insert_weight) / 100)
				c = CMD_INSERT;
			else
				c = CMD_DELETE;
			send_item(c, data_t'($urandom), pick_priority());
			if (c != CMD_SPARE)
				sent++;
		end
	endtask

	initial begin
		int i;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		send_item(CMD_DISPLAY, '0, '0);
		send_item(CMD_DELETE, '0, '0);
		send_item(CMD_SPARE, '1, '1);
		send_item(CMD_INSERT, data_t'(32'h7fff_ffff), prio_t'(16'h7fff));
		send_item(CMD_INSERT, data_t'(32'h8000_0000), prio_t'(16'h8000));
		send_item(CMD_INSERT, '0, '0);
		send_item(CMD_INSERT, '1, '1);
		for (i = 1; i <= 4; i++)
			send_item(CMD_INSERT, data_t'(i), prio_t'(5));
		send_item(CMD_INSERT, data_t'(10), '1);
		for (i = 0; i < 6; i++)
			send_item(CMD_INSERT, data_t'($urandom), pick_priority());
		send_item(CMD_INSERT, data_t'(32'h5a5a_5a5a), '0);
		send_item(CMD_DISPLAY, '1, '1);
		send_item(CMD_DELETE, '1, '1);
		send_item(CMD_DELETE, '0, '0);
		send_item(CMD_SPARE, '0, '0);
		drain();

		run_phase(9, 80);
		drain();
		run_phase(80, 9);
		drain();
		run_phase(0, 0);

		drain();
		repeat (40) @(posedge clk);
		if (mirror.pending.size() != 0)
			mirror.report_mismatch($sformatf("%0d results never arrived",
				mirror.pending.size()));

		$display("covered %0d inserts (%0d dropped as full), %0d deletes, %0d displays",
			mirror.n_insert, mirror.n_full, mirror.n_delete, mirror.n_display);
		$display("checked %0d results, %0d empty flags, %0d mismatches", mirror.checked,
			mirror.n_empty, mirror.mismatches);
		if (mirror.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
